[hw/rtl/ppid_pkg.sv]
// Shared types, widths and constants of the pitch PID balance controller.
package ppid_pkg;

  localparam int SampleW = 16;
  localparam int GainW   = 20;
  localparam int SetpW   = 17;
  localparam int LimW    = 16;
  localparam int DegW    = 17;
  localparam int DiffW   = 18;
  localparam int ErrW    = 21;
  localparam int RateW   = 22;
  localparam int IntW    = 18;
  localparam int CorrW   = 24;
  localparam int OpAW    = 23;
  localparam int OpBW    = 22;
  localparam int ProdW   = OpAW + OpBW;
  localparam int AccW    = 46;
  localparam int RndW    = AccW - 16;
  localparam int RegW    = 32;
  localparam int AddrW   = 5;
  localparam int IdxW    = 3;

  // 180/3.14159 in Q16.
  localparam logic signed [OpAW-1:0] DegK = 23'sd3754939;

  localparam logic [GainW-1:0] PropGainRst  = 20'd253;
  localparam logic [GainW-1:0] IntegGainRst = 20'd66;
  localparam logic [GainW-1:0] DerivGainRst = 20'd117965;
  localparam logic signed [SetpW-1:0] SetpointRst = -17'sd4352;
  localparam logic [LimW-1:0] LimitRst = 16'd914;

  typedef enum logic [IdxW-1:0] {
    RI_PROP_GAIN  = 3'd0,
    RI_INTEG_GAIN = 3'd1,
    RI_DERIV_GAIN = 3'd2,
    RI_SETPOINT   = 3'd3,
    RI_LIMIT      = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEG,
    ST_ERR,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_ACC,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MS_DEG,
    MS_PROP,
    MS_DERIV,
    MS_INTEG
  } mul_sel_e;

  typedef struct packed {
    logic [GainW-1:0]        prop_gain;
    logic [GainW-1:0]        integ_gain;
    logic [GainW-1:0]        deriv_gain;
    logic signed [SetpW-1:0] pitch_setpoint;
    logic [LimW-1:0]         integral_limit;
  } cfg_t;

  typedef struct packed {
    logic     load_sample;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     err_en;
    logic     integ_en;
    logic     acc_init;
    logic     acc_add;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } sts_t;

endpackage

[hw/rtl/ppid_datapath.sv]
// Datapath: shared multiplier, error, integral and accumulator registers, output stage.
module ppid_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ppid_pkg::cfg_t                       cfg_i,
  input  ppid_pkg::cmd_t                       cmd_i,
  output ppid_pkg::sts_t                       sts_o,
  input  logic signed [ppid_pkg::SampleW-1:0]  sample_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [ppid_pkg::CorrW-1:0]    corr_o,
  output logic                                 cleared_o
);
  import ppid_pkg::*;

  localparam logic signed [RndW-1:0] CorrMaxW = RndW'(32'sd8388607);
  localparam logic signed [RndW-1:0] CorrMinW = RndW'(-32'sd8388608);

  logic signed [SampleW-1:0] sample_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [ErrW-1:0]    err_q;
  logic signed [RateW-1:0]   rate_q;
  logic signed [ErrW-1:0]    last_q;
  logic signed [IntW-1:0]    integ_q;
  logic                      cleared_q;
  logic signed [AccW-1:0]    acc_q;
  logic                      out_valid_q;
  logic signed [CorrW-1:0]   corr_q;
  logic                      out_cleared_q;

  logic signed [OpAW-1:0]  op_a;
  logic signed [OpBW-1:0]  op_b;
  logic signed [ProdW-1:0] mul_res;
  logic signed [ProdW-1:0] deg_rnd;
  logic signed [DegW-1:0]  deg;
  logic signed [DiffW-1:0] diff;
  logic signed [ErrW-1:0]  err_d;
  logic signed [RateW-1:0] rate_d;
  logic signed [RateW-1:0] sum;
  logic signed [RateW-1:0] lim;
  logic                    out_of_band;
  logic signed [AccW-1:0]  acc_rnd;
  logic signed [RndW-1:0]  corr_wide;
  logic signed [CorrW-1:0] corr_sat;

  // Coefficient on side A (non-negative), variable on side B.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_DEG: begin
        op_a = DegK;
        op_b = OpBW'(sample_q);
      end
      MS_PROP: begin
        op_a = signed'({3'b000, cfg_i.prop_gain});
        op_b = OpBW'(err_q);
      end
      MS_DERIV: begin
        op_a = signed'({3'b000, cfg_i.deriv_gain});
        op_b = rate_q;
      end
      MS_INTEG: begin
        op_a = signed'({3'b000, cfg_i.integ_gain});
        op_b = OpBW'(integ_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_res = ProdW'(op_a) * ProdW'(op_b);

  // Degrees rounded half up, then the scaled error.
  assign deg_rnd = prod_q + ProdW'(48'sd1048576);
  assign deg     = signed'(deg_rnd[37:21]);
  assign diff    = DiffW'(deg) - DiffW'(cfg_i.pitch_setpoint);
  assign err_d   = (ErrW'(diff) <<< 2) + ErrW'(diff);

  assign rate_d      = RateW'(err_q) - RateW'(last_q);
  assign sum         = RateW'(err_q) + RateW'(integ_q);
  assign lim         = signed'({6'b000000, cfg_i.integral_limit});
  assign out_of_band = (sum > lim) || (sum < -lim);

  assign acc_rnd   = acc_q + AccW'(48'sd32768);
  assign corr_wide = acc_rnd[AccW-1:16];

  always_comb begin
    priority if (corr_wide > CorrMaxW) begin
      corr_sat = CorrMaxW[CorrW-1:0];
    end else if (corr_wide < CorrMinW) begin
      corr_sat = CorrMinW[CorrW-1:0];
    end else begin
      corr_sat = corr_wide[CorrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= sample_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_res;
    end
    if (cmd_i.err_en) begin
      err_q <= err_d;
    end
    if (cmd_i.integ_en) begin
      rate_q    <= rate_d;
      cleared_q <= out_of_band;
    end
    if (cmd_i.acc_init) begin
      acc_q <= AccW'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (cmd_i.out_load) begin
      corr_q        <= corr_sat;
      out_cleared_q <= cleared_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.integ_en) begin
        last_q  <= err_q;
        integ_q <= out_of_band ? '0 : sum[IntW-1:0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_stall = out_valid_q & ~out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign corr_o          = corr_q;
  assign cleared_o       = out_cleared_q;

endmodule

[hw/rtl/ppid_ctrl.sv]
// Controller: sequences one sample through the shared multiplier and accumulator.
module ppid_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ppid_pkg::sts_t sts_i,
  output ppid_pkg::cmd_t cmd_o
);
  import ppid_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_DEG;
      ST_DEG:   state_d = ST_ERR;
      ST_ERR:   state_d = ST_INTEG;
      ST_INTEG: state_d = ST_MUL_P;
      ST_MUL_P: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_MUL_I;
      ST_MUL_I: state_d = ST_ACC;
      ST_ACC:   state_d = ST_OUT;
      ST_OUT:   if (!sts_i.out_stall) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.load_sample = in_valid_i;
      end
      ST_DEG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_DEG;
      end
      ST_ERR:   cmd_o.err_en = 1'b1;
      ST_INTEG: cmd_o.integ_en = 1'b1;
      ST_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_PROP;
      end
      ST_MUL_D: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MS_DERIV;
        cmd_o.acc_init = 1'b1;
      end
      ST_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_INTEG;
        cmd_o.acc_add = 1'b1;
      end
      ST_ACC: cmd_o.acc_add = 1'b1;
      ST_OUT: cmd_o.out_load = ~sts_i.out_stall;
      default: cmd_o = '0;
    endcase
  end

endmodule

[hw/rtl/pitch_pid_balance_controller.sv]
// Top level of the pitch PID balance controller: register file, controller and datapath.
//
//   Channel   Dir  Fields (low bit first)
//   s_axis    in   tdata: pitch_sample[15:0] (radians, signed Q2.13)
//   m_axis    out  tdata: drive_correction[23:0] (Q15.8); tuser: integral_cleared
//   APB       in   five registers at byte addresses 0, 4, 8, 12, 16
//
// From acceptance to a valid result a sample passes these steps in order: accept,
// the degree multiply, the error step, the integral step, the proportional,
// derivative and integral multiplies (four on the single shared 23x22 multiplier),
// the final add, and round, saturate and load of the output register.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the previous error and the integral. A stalled output register holds
// its transaction and keeps the controller in its last step until it drains.
module pitch_pid_balance_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppid_pkg::AddrW-1:0]    paddr,
  input  logic [ppid_pkg::RegW-1:0]     pwdata,
  output logic [ppid_pkg::RegW-1:0]     prdata,
  output logic                          pready,
  // Sample stream. tdata: pitch_sample[15:0].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,
  // Correction stream. tdata: drive_correction[23:0]; tuser: integral_cleared[0].
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,
  output logic [0:0]                    m_axis_tuser
);
  import ppid_pkg::*;

  cfg_t                    cfg_q;
  cmd_t                    cmd;
  sts_t                    sts;
  logic                    cfg_we;
  reg_idx_e                widx;
  logic signed [CorrW-1:0] corr;
  logic                    cleared;

  // The register index comes from the word address; low address bits are ignored.
  assign widx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_we = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= PropGainRst;
      cfg_q.integ_gain     <= IntegGainRst;
      cfg_q.deriv_gain     <= DerivGainRst;
      cfg_q.pitch_setpoint <= SetpointRst;
      cfg_q.integral_limit <= LimitRst;
    end else if (cfg_we) begin
      unique case (widx)
        RI_PROP_GAIN:  cfg_q.prop_gain      <= pwdata[GainW-1:0];
        RI_INTEG_GAIN: cfg_q.integ_gain     <= pwdata[GainW-1:0];
        RI_DERIV_GAIN: cfg_q.deriv_gain     <= pwdata[GainW-1:0];
        RI_SETPOINT:   cfg_q.pitch_setpoint <= signed'(pwdata[SetpW-1:0]);
        RI_LIMIT:      cfg_q.integral_limit <= pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value, zero-extended; unmapped addresses read zero.
  always_comb begin
    unique case (widx)
      RI_PROP_GAIN:  prdata = RegW'(cfg_q.prop_gain);
      RI_INTEG_GAIN: prdata = RegW'(cfg_q.integ_gain);
      RI_DERIV_GAIN: prdata = RegW'(cfg_q.deriv_gain);
      RI_SETPOINT:   prdata = RegW'(unsigned'(cfg_q.pitch_setpoint));
      RI_LIMIT:      prdata = RegW'(cfg_q.integral_limit);
      default:       prdata = '0;
    endcase
  end

  ppid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppid_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (signed'(s_axis_tdata)),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .corr_o      (corr),
    .cleared_o   (cleared)
  );

  assign m_axis_tdata = unsigned'(corr);
  assign m_axis_tuser = cleared;

  // Only one sample is in flight: the input side closes right after a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  // A new result never appears in the cycle after the input side was open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result issued without a sample in flight");

  // The controller only loads the output register when it is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten while stalled");

endmodule

[sim/pitch_pid_balance_controller_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the pitch PID balance controller, with a per-sample predictor.
module pitch_pid_balance_controller_tb;
  import ppid_pkg::*;

  // The slowest correct run stays well below this bound. Each sample's time is
  // made up of a sender gap, its pass through the block and a receiver stall.
  localparam int unsigned CycleLimit = 600000;
  // Waiting this long after the last correction leaves the block idle before a
  // register write.
  localparam int DrainCycles = 16;
  // Register index that the block does not decode. Writes to it must be ignored.
  localparam logic [IdxW-1:0] SpareIdx = 3'd5;
  localparam longint CorrMax = 64'sd8388607;
  localparam longint CorrMin = -64'sd8388608;

  typedef struct packed {
    logic [CorrW-1:0] corr;
    logic             cleared;
  } correction_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [RegW-1:0]   pwdata = '0;
  logic [RegW-1:0]   prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // pitch_sample[15:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;        // drive_correction[23:0]
  logic [0:0]        m_axis_tuser;        // integral_cleared[0]

  // Samples that wait for the driver, and the corrections that the predictor
  // expects, oldest first.
  logic [15:0]       pitch_queue[$];
  correction_t       correction_q[$];

  // The predictor's own copy of the registers and of the controller state.
  cfg_t              cfg_mirror;
  longint            prev_err;
  longint            integ_sum;

  // Handshakes seen at the last rising edge, used by the drivers at the falling edge.
  logic              s_fire = 1'b0;
  logic              m_fire = 1'b0;
  // When a calm flag is set, that side runs without any idle cycles.
  logic              src_calm = 1'b0;
  logic              snk_calm = 1'b0;
  int                src_gap = 0;
  int                snk_wait = 0;
  int                walk_pos = 0;
  int                fail_count = 0;
  int unsigned       cycle_count = 0;

  pitch_pid_balance_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Works out the correction for one accepted sample and advances the state.
  // The sample is turned into degrees in Q.8 with round half up, the error is
  // five times the distance to the setpoint, and the integral is cleared as
  // soon as it leaves the band of plus or minus the limit. A sum that lands
  // exactly on the band edge is kept.
  function automatic correction_t predict_correction(input logic signed [SampleW-1:0] pitch);
    longint      deg;
    longint      err;
    longint      rate;
    longint      sum;
    longint      lim;
    longint      acc;
    longint      corr;
    correction_t res;
    deg = (longint'(pitch) * longint'(DegK) + (64'sd1 <<< 20)) >>> 21;
    err = 5 * (deg - longint'($signed(cfg_mirror.pitch_setpoint)));
    rate = err - prev_err;
    sum = integ_sum + err;
    lim = longint'(cfg_mirror.integral_limit);
    res.cleared = (sum > lim) || (sum < -lim);
    if (res.cleared) begin
      sum = 0;
    end
    integ_sum = sum;
    prev_err = err;
    acc = longint'(cfg_mirror.prop_gain) * err
        + longint'(cfg_mirror.deriv_gain) * rate
        + longint'(cfg_mirror.integ_gain) * sum;
    // The full-precision sum is in Q.24; drop 16 bits with round half up.
    corr = (acc + (64'sd1 <<< 15)) >>> 16;
    if (corr > CorrMax) begin
      corr = CorrMax;
    end
    if (corr < CorrMin) begin
      corr = CorrMin;
    end
    res.corr = corr[CorrW-1:0];
    return res;
  endfunction

  // Picks the next pitch sample. Most samples stay near the setpoint, either
  // as a slow walk or as small jitter around it, so that the integral lives
  // inside its band for a while. The rest span the whole input range.
  function automatic logic [15:0] draw_pitch();
    longint centre;
    int     pick;
    int     v;
    // Radians in Q2.13 per degree in Q.8 is about 0.5585, or 36603 / 2^16.
    centre = (longint'($signed(cfg_mirror.pitch_setpoint)) * 36603) >>> 16;
    if (centre > 32767) begin
      centre = 32767;
    end
    if (centre < -32768) begin
      centre = -32768;
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else if (pick < 7) begin
      v = walk_pos + int'($urandom_range(0, 40)) - 20;
    end else begin
      v = int'(centre) + int'($urandom_range(0, 16)) - 8;
    end
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    walk_pos = v;
    return v[15:0];
  endfunction

  // One APB write: a setup phase, then an access phase. pready is always
  // high, so the register takes the value at the rising edge of the access
  // phase. The mirror keeps only the bits that the register holds.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [RegW-1:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      RI_PROP_GAIN:  cfg_mirror.prop_gain = value[GainW-1:0];
      RI_INTEG_GAIN: cfg_mirror.integ_gain = value[GainW-1:0];
      RI_DERIV_GAIN: cfg_mirror.deriv_gain = value[GainW-1:0];
      RI_SETPOINT:   cfg_mirror.pitch_setpoint = value[SetpW-1:0];
      RI_LIMIT:      cfg_mirror.integral_limit = value[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [RegW-1:0] pg, input logic [RegW-1:0] ig,
                           input logic [RegW-1:0] dg, input logic [RegW-1:0] sp,
                           input logic [RegW-1:0] lim);
    write_reg(RI_PROP_GAIN, pg);
    write_reg(RI_INTEG_GAIN, ig);
    write_reg(RI_DERIV_GAIN, dg);
    write_reg(RI_SETPOINT, sp);
    write_reg(RI_LIMIT, lim);
  endtask

  // Waits until every queued sample is sent and every expected correction has
  // arrived, then lets the block settle so that a register write finds it idle.
  task automatic wait_drain();
    while (pitch_queue.size() != 0 || s_axis_tvalid || correction_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    walk_pos = 0;
    repeat (count) pitch_queue.push_back(draw_pitch());
    wait_drain();
  endtask

  function automatic logic [RegW-1:0] rand_gain();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 1023);
      1:       return $urandom_range(0, 131071);
      default: return $urandom_range(0, 20'hFFFFF);
    endcase
  endfunction

  // Sample driver. A transaction that is offered stays on the bus until it is
  // taken. Between transactions the sender idles for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_fire) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pitch_queue.size() != 0) begin
        s_axis_tdata <= pitch_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 63) == 0) begin
          src_calm = !src_calm;
        end
        src_gap = src_calm ? 0 : $urandom_range(0, 5);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Correction sink. After each transaction it stalls for a drawn number of
  // cycles, which also stretches over cycles where the block has nothing to send.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_fire) begin
        if ($urandom_range(0, 63) == 0) begin
          snk_calm = !snk_calm;
        end
        snk_wait = snk_calm ? 0 : $urandom_range(0, 5);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor. Both streams are sampled at the rising edge: an accepted sample
  // feeds the predictor, and an accepted correction is held against the
  // oldest expectation.
  always @(posedge clk_i) begin
    correction_t want;
    s_fire <= s_axis_tvalid && s_axis_tready;
    m_fire <= m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      correction_q.push_back(predict_correction(s_axis_tdata));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (correction_q.size() == 0) begin
        $display("%0t: correction %h with integral_cleared %b arrived, none expected",
                 $time, m_axis_tdata, m_axis_tuser[0]);
        fail_count++;
      end else begin
        want = correction_q.pop_front();
        if (m_axis_tdata !== want.corr) begin
          $display("%0t: drive_correction expected %h, actual %h",
                   $time, want.corr, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.cleared) begin
          $display("%0t: integral_cleared expected %b, actual %b",
                   $time, want.cleared, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog against a block that stops answering.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cfg_mirror = '{PropGainRst, IntegGainRst, DerivGainRst, SetpointRst, LimitRst};
    prev_err = 0;
    integ_sum = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Register defaults after reset: the extremes of the sample range, the
    // alternating bit patterns and a few samples as near the setpoint as the input allows.
    pitch_queue.push_back(16'h0000);
    pitch_queue.push_back(16'h7FFF);
    pitch_queue.push_back(16'h8000);
    pitch_queue.push_back(16'h0001);
    pitch_queue.push_back(16'hFFFF);
    pitch_queue.push_back(16'h5555);
    pitch_queue.push_back(16'hAAAA);
    repeat (3) pitch_queue.push_back(16'hF681);
    pitch_queue.push_back(16'h7FFF);
    wait_drain();

    // A write to an address without a register changes nothing.
    write_reg(SpareIdx, 32'hFFFF_FFFF);

    // A setpoint of one LSB below zero gives an error of +5 per zero sample.
    // With a limit of 10 the integral reaches the band edge, is kept there,
    // and is cleared by the next step.
    configure(32'd65536, 32'd65536, 32'd65536, -32'sd1, 32'd10);
    repeat (4) pitch_queue.push_back(16'h0000);
    wait_drain();
    // The same at the lower edge of the band.
    write_reg(RI_SETPOINT, 32'd1);
    repeat (4) pitch_queue.push_back(16'h0000);
    wait_drain();

    // Defaults again, then the register extremes, then random settings.
    configure(32'd253, 32'd66, 32'd117965, -32'sd4352, 32'd914);
    run_random(160);
    // Gains of zero give a correction of zero; a zero band clears on any error.
    configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_random(140);
    // Bits above each register's width are dropped, leaving the largest
    // gains, and the correction saturates.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sd46080, 32'hFFFF_FFFF);
    run_random(140);
    configure(32'd4096, 32'd512, 32'd65536, -32'sd46080, 32'd65535);
    run_random(140);
    // Setpoints outside their nominal range are used as they are.
    configure(32'd253, 32'd66, 32'd117965, 32'h0001_0000, 32'd2000);
    run_random(120);
    write_reg(RI_SETPOINT, 32'h0000_FFFF);
    run_random(120);
    repeat (6) begin
      configure(rand_gain(), rand_gain(), rand_gain(),
                32'(int'($urandom_range(0, 92160)) - 46080),
                ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2000)
                                            : $urandom_range(0, 65535));
      run_random(140);
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
